// ===== rtl/core/jrd_pkg.sv =====
// shared widths, constants and the cordic arctangent table
package jrd_pkg;

   localparam int FRAC_BITS   = 15;
   localparam int EXT_BITS    = 8;
   localparam int AXIS_W      = 16;
   localparam int LEN_W       = 24;
   localparam int ROOT_LAT    = 25;
   localparam int CORDIC_W    = 27;
   localparam int MAX_STAGES  = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_INNER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTER = 1'b1;

   localparam logic [15:0] INNER_RESET = 16'd0;
   localparam logic [15:0] OUTER_RESET = 16'h8000;

   typedef logic signed [AXIS_W-1:0] axis_type;
   typedef logic [AXIS_W-1:0]        mag_type;
   typedef logic [LEN_W-1:0]         len_type;
   typedef logic signed [CORDIC_W-1:0] cordic_type;

   // atan(2^-i) in 2^-16 degree
   function automatic cordic_type atan_entry(input int unsigned idx);
      cordic_type val;
      case (idx)
         0:       val = 27'sd2949120;
         1:       val = 27'sd1740967;
         2:       val = 27'sd919879;
         3:       val = 27'sd466945;
         4:       val = 27'sd234379;
         5:       val = 27'sd117304;
         6:       val = 27'sd58666;
         7:       val = 27'sd29335;
         8:       val = 27'sd14668;
         9:       val = 27'sd7334;
         10:      val = 27'sd3667;
         11:      val = 27'sd1833;
         12:      val = 27'sd917;
         13:      val = 27'sd458;
         14:      val = 27'sd229;
         15:      val = 27'sd115;
         16:      val = 27'sd57;
         17:      val = 27'sd29;
         18:      val = 27'sd14;
         19:      val = 27'sd7;
         20:      val = 27'sd4;
         21:      val = 27'sd2;
         22:      val = 27'sd1;
         default: val = 27'sd0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/core/jrd_req_if.sv =====
// request channel carrying one raw stick sample
interface jrd_req_if;
   import jrd_pkg::*;
   logic     valid;
   logic     ready;
   axis_type raw_x;
   axis_type raw_y;
   modport source (output valid, raw_x, raw_y, input ready);
   modport sink   (input valid, raw_x, raw_y, output ready);
endinterface

// ===== rtl/core/jrd_rsp_if.sv =====
// response channel carrying one corrected sample
interface jrd_rsp_if;
   import jrd_pkg::*;
   logic     valid;
   logic     ready;
   axis_type corr_x;
   axis_type corr_y;
   mag_type  corr_magnitude;
   axis_type angle_deg;
   modport source (output valid, corr_x, corr_y, corr_magnitude, angle_deg, input ready);
   modport sink   (input valid, corr_x, corr_y, corr_magnitude, angle_deg, output ready);
endinterface

// ===== rtl/core/joystick_radial_deadzone.sv =====
// radial dead zone remap from request to response valid
// throughput one transaction per cycle; the whole pipeline advances together
// and holds when the response is valid but not taken, so nothing is lost
// the length path is a 24-stage square root and two 16/17-stage dividers
// synchronous active-high reset clears valid bits and sets the thresholds
// to inner 0 and outer 1.0
module joystick_radial_deadzone #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   jrd_req_if.sink                           req,
   jrd_rsp_if.source                         rsp,
   input  logic                              csr_wr_en,
   input  logic [jrd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [jrd_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import jrd_pkg::*;

   typedef enum logic [1:0] {
      MAG_ZERO,
      MAG_FULL,
      MAG_DIV
   } mag_case_type;

   localparam int MAG_QW   = 16;
   localparam int MAG_NW   = 40;
   localparam int AXIS_QW  = 17;
   localparam int AXIS_NW  = 42;
   localparam int MAG_SBW  = 2 + LEN_W + 2 * AXIS_W;
   localparam int XSB_W    = 2 + AXIS_W;
   // registers ahead of the output register on the length path
   localparam int PRE_OUT  = ROOT_LAT + 1 + MAG_QW + 1 + AXIS_QW;
   localparam int ANG_DLY  = PRE_OUT - (CORDIC_STAGES + 2);

   // thresholds; the user must write them only while the pipeline is empty, the block does not enforce it
   logic [15:0] inner_ff;
   logic [15:0] outer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= INNER_RESET;
         outer_ff <= OUTER_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_INNER: inner_ff <= csr_wr_data;
            REG_OUTER: outer_ff <= csr_wr_data;
            default:   ;
         endcase
      end
   end

   // single pipeline enable: move unless the output holds an untaken result
   logic out_v_ff;
   logic en;
   assign en        = rsp.ready || !out_v_ff;
   assign req.ready = en;

   // length
   logic     root_v;
   len_type  root_len;
   axis_type root_x;
   axis_type root_y;

   jrd_root u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req.valid),
      .in_x      (req.raw_x),
      .in_y      (req.raw_y),
      .out_valid (root_v),
      .out_len   (root_len),
      .out_x     (root_x),
      .out_y     (root_y)
   );

   // classify the length against the thresholds
   len_type      lo;
   len_type      hi;
   mag_case_type cls_case;

   assign lo = {inner_ff, 8'b0};
   assign hi = {outer_ff, 8'b0};

   always_comb begin
      if (root_len < lo) begin
         cls_case = MAG_ZERO;
      end else if (root_len > hi) begin
         cls_case = MAG_FULL;
      end else if (hi == lo) begin
         cls_case = MAG_ZERO;   // equal thresholds, no divide
      end else begin
         cls_case = MAG_DIV;
      end
   end

   logic         cls_v_ff;
   mag_case_type cls_case_ff;
   len_type      cls_dl_ff;
   len_type      cls_d_ff;
   len_type      cls_len_ff;
   axis_type     cls_x_ff;
   axis_type     cls_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_v_ff <= 1'b0;
      end else if (en) begin
         cls_v_ff <= root_v;
      end
      if (en) begin
         cls_case_ff <= cls_case;
         cls_dl_ff   <= root_len - lo;
         cls_d_ff    <= hi - lo;
         cls_len_ff  <= root_len;
         cls_x_ff    <= root_x;
         cls_y_ff    <= root_y;
      end
   end

   // remap (len - inner) / (outer - inner) onto 0..1.0
   logic               md_v;
   logic [MAG_QW-1:0]  md_q;
   logic [MAG_SBW-1:0] md_side;

   jrd_div #(
      .NW  (MAG_NW),
      .DW  (LEN_W),
      .QW  (MAG_QW),
      .SBW (MAG_SBW)
   ) u_mag_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cls_v_ff),
      .num       ({1'b0, cls_dl_ff, 15'b0}),
      .den       (cls_d_ff),
      .in_side   ({cls_case_ff, cls_len_ff, cls_x_ff, cls_y_ff}),
      .out_valid (md_v),
      .quo       (md_q),
      .out_side  (md_side)
   );

   mag_case_type md_case;
   len_type      md_len;
   axis_type     md_x;
   axis_type     md_y;
   mag_type      mag_sel;
   mag_type      abs_x;
   mag_type      abs_y;
   logic [31:0]  prod_x;
   logic [31:0]  prod_y;

   assign md_case                = mag_case_type'(md_side[MAG_SBW-1 -: 2]);
   assign {md_len, md_x, md_y}   = md_side[MAG_SBW-3:0];

   always_comb begin
      case (md_case)
         MAG_FULL: mag_sel = OUTER_RESET;
         MAG_DIV:  mag_sel = md_q;
         default:  mag_sel = '0;
      endcase
   end

   assign abs_x  = md_x[AXIS_W-1] ? mag_type'(-md_x) : mag_type'(md_x);
   assign abs_y  = md_y[AXIS_W-1] ? mag_type'(-md_y) : mag_type'(md_y);
   assign prod_x = mag_sel * abs_x;
   assign prod_y = mag_sel * abs_y;

   // scaled axis numerators, rounding term folded in
   logic               mul_v_ff;
   logic [AXIS_NW-1:0] mul_nx_ff;
   logic [AXIS_NW-1:0] mul_ny_ff;
   logic [LEN_W:0]     mul_d_ff;
   logic               mul_sx_ff;
   logic               mul_sy_ff;
   logic               mul_zero_ff;
   mag_type            mul_mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
      end else if (en) begin
         mul_v_ff <= md_v;
      end
      if (en) begin
         mul_nx_ff   <= {1'b0, prod_x, 9'b0} + AXIS_NW'(md_len);
         mul_ny_ff   <= {1'b0, prod_y, 9'b0} + AXIS_NW'(md_len);
         mul_d_ff    <= {md_len, 1'b0};
         mul_sx_ff   <= md_x[AXIS_W-1];
         mul_sy_ff   <= md_y[AXIS_W-1];
         mul_zero_ff <= (md_len == '0);
         mul_mag_ff  <= mag_sel;
      end
   end

   logic               ax_v;
   logic [AXIS_QW-1:0] ax_q;
   logic [XSB_W-1:0]   ax_side;
   logic               ay_v;
   logic [AXIS_QW-1:0] ay_q;
   logic               ay_sign;

   jrd_div #(
      .NW  (AXIS_NW),
      .DW  (LEN_W + 1),
      .QW  (AXIS_QW),
      .SBW (XSB_W)
   ) u_x_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mul_v_ff),
      .num       (mul_nx_ff),
      .den       (mul_d_ff),
      .in_side   ({mul_sx_ff, mul_zero_ff, mul_mag_ff}),
      .out_valid (ax_v),
      .quo       (ax_q),
      .out_side  (ax_side)
   );

   jrd_div #(
      .NW  (AXIS_NW),
      .DW  (LEN_W + 1),
      .QW  (AXIS_QW),
      .SBW (1)
   ) u_y_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mul_v_ff),
      .num       (mul_ny_ff),
      .den       (mul_d_ff),
      .in_side   (mul_sy_ff),
      .out_valid (ay_v),
      .quo       (ay_q),
      .out_side  (ay_sign)
   );

   // angle runs alongside and is delayed to line up with the axis results
   axis_type cordic_angle;
   axis_type ang_dly_ff [0:ANG_DLY-1];

   jrd_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock (clock),
      .en    (en),
      .in_x  (req.raw_x),
      .in_y  (req.raw_y),
      .angle (cordic_angle)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         ang_dly_ff[0] <= cordic_angle;
         for (int k = 1; k < ANG_DLY; k++) begin
            ang_dly_ff[k] <= ang_dly_ff[k-1];
         end
      end
   end

   // saturate, apply signs, zero input gives all zeros
   logic     fin_sx;
   logic     fin_zero;
   mag_type  fin_mag;
   axis_type sat_x;
   axis_type sat_y;

   assign {fin_sx, fin_zero, fin_mag} = ax_side;
   assign sat_x = (ax_q > AXIS_QW'(32767)) ? 16'sd32767 : axis_type'({1'b0, ax_q[14:0]});
   assign sat_y = (ay_q > AXIS_QW'(32767)) ? 16'sd32767 : axis_type'({1'b0, ay_q[14:0]});

   axis_type out_x_ff;
   axis_type out_y_ff;
   mag_type  out_mag_ff;
   axis_type out_ang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= ax_v && ay_v;
      end
      if (en) begin
         if (fin_zero) begin
            out_x_ff   <= '0;
            out_y_ff   <= '0;
            out_mag_ff <= '0;
            out_ang_ff <= '0;
         end else begin
            out_x_ff   <= fin_sx  ? -sat_x : sat_x;
            out_y_ff   <= ay_sign ? -sat_y : sat_y;
            out_mag_ff <= fin_mag;
            out_ang_ff <= ang_dly_ff[ANG_DLY-1];
         end
      end
   end

   assign rsp.valid          = out_v_ff;
   assign rsp.corr_x         = out_x_ff;
   assign rsp.corr_y         = out_y_ff;
   assign rsp.corr_magnitude = out_mag_ff;
   assign rsp.angle_deg      = out_ang_ff;

endmodule

// ===== rtl/core/jrd_root.sv =====
// squared length followed by a bit-per-stage pipelined square root
module jrd_root (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  jrd_pkg::axis_type in_x,
   input  jrd_pkg::axis_type in_y,
   output logic             out_valid,
   output jrd_pkg::len_type out_len,
   output jrd_pkg::axis_type out_x,
   output jrd_pkg::axis_type out_y
);
   import jrd_pkg::*;

   localparam int SQ_W  = 32;
   localparam int RAD_W = 48;
   localparam int STEPS = ROOT_LAT - 1;

   logic              v_ff    [0:STEPS];
   axis_type          x_ff    [0:STEPS];
   axis_type          y_ff    [0:STEPS];
   logic [RAD_W-1:0]  rem_ff  [0:STEPS];
   logic [RAD_W-1:0]  root_ff [0:STEPS];

   logic signed [SQ_W-1:0] xx;
   logic signed [SQ_W-1:0] yy;
   logic [SQ_W-1:0]        sq;

   assign xx = in_x * in_x;
   assign yy = in_y * in_y;
   assign sq = SQ_W'(unsigned'(xx)) + SQ_W'(unsigned'(yy));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0]    <= in_x;
         y_ff[0]    <= in_y;
         rem_ff[0]  <= {sq, 16'b0};
         root_ff[0] <= '0;
      end
   end

   for (genvar s = 1; s <= STEPS; s++) begin : g_step
      localparam int BIT_POS = RAD_W - 2 - 2 * (s - 1);
      logic [RAD_W-1:0] bit_w;
      logic [RAD_W-1:0] trial;
      logic [RAD_W-1:0] rem_in;
      logic [RAD_W-1:0] root_in;

      assign bit_w = RAD_W'(1) << BIT_POS;
      assign trial = root_ff[s-1] + bit_w;

      always_comb begin
         if (rem_ff[s-1] >= trial) begin
            rem_in  = rem_ff[s-1] - trial;
            root_in = (root_ff[s-1] >> 1) + bit_w;
         end else begin
            rem_in  = rem_ff[s-1];
            root_in = root_ff[s-1] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_ff[s-1];
         end
         if (en) begin
            x_ff[s]    <= x_ff[s-1];
            y_ff[s]    <= y_ff[s-1];
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_len   = root_ff[STEPS][LEN_W-1:0];
   assign out_x     = x_ff[STEPS];
   assign out_y     = y_ff[STEPS];

endmodule

// ===== rtl/core/jrd_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module jrd_div #(
   parameter int NW  = 40,
   parameter int DW  = 24,
   parameter int QW  = 16,
   parameter int SBW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [NW-1:0]  num,
   input  logic [DW-1:0]  den,
   input  logic [SBW-1:0] in_side,
   output logic           out_valid,
   output logic [QW-1:0]  quo,
   output logic [SBW-1:0] out_side
);

   logic           v_ff    [0:QW-1];
   logic [NW-1:0]  rem_ff  [0:QW-1];
   logic [QW-1:0]  quo_ff  [0:QW-1];
   logic [DW-1:0]  den_ff  [0:QW-1];
   logic [SBW-1:0] side_ff [0:QW-1];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      logic           v_src;
      logic [NW-1:0]  rem_src;
      logic [QW-1:0]  quo_src;
      logic [DW-1:0]  den_src;
      logic [SBW-1:0] side_src;
      logic [NW-1:0]  den_sh;
      logic           take;

      if (j == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = num;
         assign quo_src  = '0;
         assign den_src  = den;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[j-1];
         assign rem_src  = rem_ff[j-1];
         assign quo_src  = quo_ff[j-1];
         assign den_src  = den_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      assign den_sh = {{(NW-DW){1'b0}}, den_src} << (QW - 1 - j);
      assign take   = rem_src >= den_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_src;
         end
         if (en) begin
            rem_ff[j]  <= take ? rem_src - den_sh : rem_src;
            quo_ff[j]  <= quo_src | (QW'(take) << (QW - 1 - j));
            den_ff[j]  <= den_src;
            side_ff[j] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign quo       = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

// ===== rtl/core/jrd_cordic.sv =====
// pipelined vectoring cordic giving the angle in 1/128 degree
module jrd_cordic #(
   parameter int STAGES = 16
) (
   input  logic              clock,
   input  logic              en,
   input  jrd_pkg::axis_type in_x,
   input  jrd_pkg::axis_type in_y,
   output jrd_pkg::axis_type angle
);
   import jrd_pkg::*;

   localparam cordic_type HALF_TURN = 27'sd11796480;
   localparam cordic_type LIMIT     = 27'sd23040;

   cordic_type x_ff [0:STAGES];
   cordic_type y_ff [0:STAGES];
   cordic_type z_ff [0:STAGES];
   axis_type   angle_ff;

   cordic_type xe;
   cordic_type ye;

   assign xe = {{3{in_x[AXIS_W-1]}}, in_x, 8'b0};
   assign ye = {{3{in_y[AXIS_W-1]}}, in_y, 8'b0};

   // fold the left half plane over by a half turn
   always_ff @(posedge clock) begin
      if (en) begin
         if (in_x[AXIS_W-1]) begin
            x_ff[0] <= -xe;
            y_ff[0] <= -ye;
            z_ff[0] <= in_y[AXIS_W-1] ? -HALF_TURN : HALF_TURN;
         end else begin
            x_ff[0] <= xe;
            y_ff[0] <= ye;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 1; i <= STAGES; i++) begin : g_rot
      cordic_type xs;
      cordic_type ys;
      assign xs = x_ff[i-1] >>> (i - 1);
      assign ys = y_ff[i-1] >>> (i - 1);
      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_ff[i-1][CORDIC_W-1]) begin
               x_ff[i] <= x_ff[i-1] + ys;
               y_ff[i] <= y_ff[i-1] - xs;
               z_ff[i] <= z_ff[i-1] + atan_entry(i - 1);
            end else begin
               x_ff[i] <= x_ff[i-1] - ys;
               y_ff[i] <= y_ff[i-1] + xs;
               z_ff[i] <= z_ff[i-1] - atan_entry(i - 1);
            end
         end
      end
   end

   cordic_type z_round;
   assign z_round = (z_ff[STAGES] + 27'sd256) >>> 9;

   always_ff @(posedge clock) begin
      if (en) begin
         if (z_round > LIMIT) begin
            angle_ff <= AXIS_W'(LIMIT);
         end else if (z_round < -LIMIT) begin
            angle_ff <= AXIS_W'(-LIMIT);
         end else begin
            angle_ff <= z_round[AXIS_W-1:0];
         end
      end
   end

   assign angle = angle_ff;

endmodule

// ===== tb/joystick_radial_deadzone_checker.sv =====
// checker: watches the sample and result channels, predicts each result and compares it
module joystick_radial_deadzone_checker (
   input  logic                            clock,
   input  logic                            reset,
   jrd_req_if                              req_mon,
   jrd_rsp_if                              rsp_mon,
   input  logic                            csr_wr_en,
   input  logic [jrd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [jrd_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import jrd_pkg::*;

   localparam int ANGLE_STAGES = 16;
   localparam longint ANGLE_LIMIT = 23040;
   localparam longint AXIS_LIMIT  = 32767;

   typedef struct packed {
      axis_type corr_x;
      axis_type corr_y;
      mag_type  corr_magnitude;
      axis_type angle_deg;
   } corrected_type;

   // arctangent of 2^-i in 2^-16 degree
   localparam longint ARCTAN_STEP [0:MAX_STAGES-1] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   logic [15:0]   inner_r;
   logic [15:0]   outer_r;
   corrected_type expected_q[$];
   int            mismatch_count;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v -= root + bitpos;
            root = (root >> 1) + bitpos;
         end else begin
            root >>= 1;
         end
         bitpos >>= 2;
      end
      return root;
   endfunction

   function automatic longint scale_axis(input longint a, input longint unsigned mag,
                                         input longint unsigned len);
      longint unsigned ua;
      longint unsigned q;
      ua = (a < 0) ? -a : a;
      q = (2 * (mag * (ua << 8)) + len) / (2 * len);
      if (q > AXIS_LIMIT) q = AXIS_LIMIT;
      return (a < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint stick_angle(input longint x, input longint y);
      longint z;
      longint xs;
      longint ys;
      z = 0;
      x = x * 256;
      y = y * 256;
      // fold the left half plane over by half a turn
      if (x < 0) begin
         z = (y >= 0) ? 180 * 65536 : -180 * 65536;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < ANGLE_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z += ARCTAN_STEP[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z -= ARCTAN_STEP[i];
         end
      end
      z = (z + 256) >>> 9;
      if (z > ANGLE_LIMIT) z = ANGLE_LIMIT;
      if (z < -ANGLE_LIMIT) z = -ANGLE_LIMIT;
      return z;
   endfunction

   function automatic corrected_type remap_sample(input axis_type rx, input axis_type ry);
      longint x;
      longint y;
      longint unsigned len;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mag;
      corrected_type res;
      x = rx;
      y = ry;
      len = int_sqrt(longint'(x * x + y * y) << 16);
      lo = longint'(inner_r) << 8;
      hi = longint'(outer_r) << 8;
      res = '0;
      if (len != 0) begin
         if (len < lo) mag = 0;
         else if (len > hi) mag = 32768;
         else if (hi == lo) mag = 0;
         else mag = ((len - lo) * 32768) / (hi - lo);
         res.corr_x = axis_type'(scale_axis(x, mag, len));
         res.corr_y = axis_type'(scale_axis(y, mag, len));
         res.corr_magnitude = mag_type'(mag);
         res.angle_deg = axis_type'(stick_angle(x, y));
      end
      return res;
   endfunction

   // everything is sampled mid-cycle, so a handshake seen here completes at the next edge
   always @(negedge clock) begin
      corrected_type exp_r;
      corrected_type got;
      if (reset) begin
         inner_r = INNER_RESET;
         outer_r = OUTER_RESET;
         expected_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == REG_INNER) inner_r = csr_wr_data;
            else if (csr_index == REG_OUTER) outer_r = csr_wr_data;
         end
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(remap_sample(req_mon.raw_x, req_mon.raw_y));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.corr_x, rsp_mon.corr_y, rsp_mon.corr_magnitude, rsp_mon.angle_deg};
            if (expected_q.size() == 0) begin
               fail_count++;
               if (mismatch_count++ < 10)
                  $display("unexpected result: x %0d y %0d mag %0d ang %0d",
                           got.corr_x, got.corr_y, got.corr_magnitude, got.angle_deg);
            end else begin
               exp_r = expected_q.pop_front();
               if (got != exp_r) begin
                  fail_count++;
                  if (mismatch_count++ < 10)
                     $display("mismatch: x %0d/%0d y %0d/%0d mag %0d/%0d ang %0d/%0d (exp/got)",
                              exp_r.corr_x, got.corr_x, exp_r.corr_y, got.corr_y,
                              exp_r.corr_magnitude, got.corr_magnitude,
                              exp_r.angle_deg, got.angle_deg);
               end
            end
         end
      end
      pending = expected_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      mismatch_count = 0;
      inner_r = INNER_RESET;
      outer_r = OUTER_RESET;
   end

endmodule

// ===== tb/joystick_radial_deadzone_tb.sv =====
// testbench top: drives stick samples and threshold writes, gives the verdict
module joystick_radial_deadzone_tb;
   import jrd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES      = 7;
   localparam int RANDOM_ITEMS = 258;
   localparam int DRAIN_WAIT  = 80;     // margin beyond the pipeline latency
   localparam int STALL_LEN   = 400;    // long receiver hold-off
   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   int  fail_count;
   int  pending;
   int  cycles;
   int  snd_idle_pct;
   int  rsp_idle_pct;
   logic stall_go;
   logic stall_done;

   // threshold settings per phase: defaults, both zero, equal, inner above outer,
   // full-scale, maximum raw codes, a normal window
   localparam logic [15:0] INNER_SET [0:PHASES-1] =
      '{16'd0, 16'd0, 16'd16384, 16'd30000, 16'd32768, 16'd65535, 16'd3277};
   localparam logic [15:0] OUTER_SET [0:PHASES-1] =
      '{16'd32768, 16'd0, 16'd16384, 16'd1000, 16'd32768, 16'd65535, 16'd29491};

   jrd_req_if req_ch ();
   jrd_rsp_if rsp_ch ();

   joystick_radial_deadzone u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch.sink),
      .rsp         (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   joystick_radial_deadzone_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // 2 ns clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result receiver: random back-pressure plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_go && !stall_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (STALL_LEN) @(posedge clock);
            stall_done = 1'b1;
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // one stick sample transaction, with optional idle cycles ahead of it
   task automatic send_sample(input axis_type x, input axis_type y);
      logic hit;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.raw_x <= x;
      req_ch.raw_y <= y;
      do begin
         @(negedge clock);
         hit = req_ch.ready;
         @(posedge clock);
      end while (!hit);
   endtask

   // mix of full-range codes, mid-range codes, small deflections near the center and near full scale
   function automatic axis_type random_axis();
      int sel;
      sel = $urandom_range(3);
      case (sel)
         0: return axis_type'($urandom);
         1: return axis_type'($urandom_range(1200) - 600);
         2: return ($urandom_range(1)) ? axis_type'($urandom_range(32767, 31000))
                                       : axis_type'(-int'($urandom_range(32768, 31000)));
         default: return axis_type'($urandom_range(40000) - 20000);
      endcase
   endfunction

   // write both thresholds once the pipeline has drained
   task automatic load_thresholds(input logic [15:0] inner, input logic [15:0] outer);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= REG_INNER;
      csr_wr_data <= inner;
      @(posedge clock);
      csr_index   <= REG_OUTER;
      csr_wr_data <= outer;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      cycles = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = REG_INNER;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.raw_x = '0;
      req_ch.raw_y = '0;
      snd_idle_pct = 0;
      rsp_idle_pct = 0;
      stall_go = 1'b0;
      stall_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < PHASES; p++) begin
         load_thresholds(INNER_SET[p], OUTER_SET[p]);
         // idling pattern rotates: receiver-heavy, sender-heavy, none
         case (p % 3)
            0: begin snd_idle_pct = 36; rsp_idle_pct = 81; end
            1: begin snd_idle_pct = 81; rsp_idle_pct = 36; end
            default: begin snd_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         // fill the pipeline against a stalled receiver
         if (p == 2) stall_go = 1'b1;
         if (p == 0) begin
            // zero sample, corners, axis extremes, sign flips across the fold
            send_sample(16'sd0, 16'sd0);
            send_sample(-16'sd32768, -16'sd32768);
            send_sample(16'sd32767, 16'sd32767);
            send_sample(-16'sd32768, 16'sd32767);
            send_sample(16'sd32767, -16'sd32768);
            send_sample(-16'sd32768, 16'sd0);
            send_sample(16'sd0, -16'sd32768);
            send_sample(16'sd32767, 16'sd0);
            send_sample(16'sd0, 16'sd32767);
            send_sample(-16'sd1, 16'sd0);
            send_sample(16'sd1, 16'sd0);
            send_sample(16'sd0, -16'sd1);
            send_sample(16'sd0, 16'sd1);
            send_sample(-16'sd32768, 16'sd1);
            send_sample(-16'sd32768, -16'sd1);
            send_sample(-16'sd1, -16'sd1);
            send_sample(16'sd23170, 16'sd23170);
            send_sample(-16'sd23170, 16'sd23170);
            send_sample(16'sd100, -16'sd3);
         end
         for (int i = 0; i < RANDOM_ITEMS; i++)
            send_sample(random_axis(), random_axis());
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/jrd_pkg.sv
rtl/core/jrd_req_if.sv
rtl/core/jrd_rsp_if.sv
rtl/core/jrd_root.sv
rtl/core/jrd_div.sv
rtl/core/jrd_cordic.sv
rtl/core/joystick_radial_deadzone.sv
tb/joystick_radial_deadzone_checker.sv
tb/joystick_radial_deadzone_tb.sv
